@@ hdl/smm_pkg.sv @@
// smm_pkg: shared types and constants for the square matrix multiply block
// no dependencies; used by square_matrix_multiply_top and smm_checker

package smm_pkg;

   localparam int MAX_DIM_DEFAULT = 16;

   localparam int          MATRIX_SIZE_W     = 5;
   localparam logic [4:0]  MATRIX_SIZE_RESET = 5'd16;

   localparam int          CSR_ADDR_W        = 3;
   localparam logic [2:0]  CSR_MATRIX_SIZE   = 3'd0;

   localparam logic        REQ_LOAD = 1'b0;
   localparam logic        REQ_READ = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [3:0]         row_index;
      logic [3:0]         col_index;
      logic signed [31:0] a_value;
      logic signed [31:0] b_value;
   } req_beat_type;

   typedef struct packed {
      logic [3:0]         out_row;
      logic [3:0]         out_col;
      logic signed [31:0] product_value;
      logic               out_of_range;
   } rsp_beat_type;

endpackage

@@ hdl/square_matrix_multiply_top.sv @@
// square_matrix_multiply_top: element stores for A and B, one shared mac under a sequencer
// depends on smm_pkg
// a load beat writes both stores when in range, without going busy; an in-range read holds busy
// through RUN and DRAIN, its result shown as busy falls; an out-of-range read answers in the next
// cycle without going busy; the read time is set by the single multiply-accumulate walking one k per cycle
// reset is synchronous, active high: sequencer idle, matrix_size back to 16, stores untouched
// results are shown for one cycle on rsp_valid; the receiver cannot stall them

module square_matrix_multiply_top #(
   parameter int MAX_DIM = smm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  smm_pkg::req_beat_type               req_data,
   output logic                                rsp_valid,
   output smm_pkg::rsp_beat_type               rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [smm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int K_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int SZ_W   = ($clog2(MAX_DIM + 1) > smm_pkg::MATRIX_SIZE_W) ?
                           $clog2(MAX_DIM + 1) : smm_pkg::MATRIX_SIZE_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [4:0]            matrix_size_ff, matrix_size_in;
   logic [3:0]            row_ff, row_in;
   logic [3:0]            col_ff, col_in;
   logic [K_W-1:0]        k_ff, k_in;
   logic [K_W-1:0]        last_k_ff, last_k_in;
   logic [31:0]           acc_ff, acc_in;
   logic                  rd_v_ff, prod_v_ff;
   logic [31:0]           a_rd_ff, b_rd_ff, prod_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   smm_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;

   logic [31:0]           store_a_ff [DEPTH];
   logic [31:0]           store_b_ff [DEPTH];

   logic [SZ_W-1:0]       act_size;
   logic                  in_range;
   logic                  accept;
   logic                  wr_en;
   logic                  csr_wr;
   logic [ADDR_W-1:0]     wr_addr, a_addr, b_addr;

   // configuration
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == smm_pkg::CSR_MATRIX_SIZE);
   assign matrix_size_in = csr_wr ? pwdata[4:0] : matrix_size_ff;
   assign prdata = (paddr == smm_pkg::CSR_MATRIX_SIZE) ? {27'd0, matrix_size_ff} : 32'd0;

   assign act_size = (SZ_W'(matrix_size_ff) > SZ_W'(MAX_DIM)) ?
                     SZ_W'(MAX_DIM) : SZ_W'(matrix_size_ff);
   assign in_range = (SZ_W'(req_data.row_index) < act_size) &&
                     (SZ_W'(req_data.col_index) < act_size);

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign wr_en  = accept && (req_data.req_type == smm_pkg::REQ_LOAD) && in_range;

   assign wr_addr = ADDR_W'(int'(req_data.row_index) * MAX_DIM + int'(req_data.col_index));
   assign a_addr  = ADDR_W'(int'(row_ff) * MAX_DIM + int'(k_ff));
   assign b_addr  = ADDR_W'(int'(k_ff) * MAX_DIM + int'(col_ff));

   // element stores
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_a_ff[wr_addr] <= req_data.a_value;
         store_b_ff[wr_addr] <= req_data.b_value;
      end
      a_rd_ff <= store_a_ff[a_addr];
      b_rd_ff <= store_b_ff[b_addr];
   end

   // shared mac
   always_ff @(posedge clock) begin
      prod_ff <= a_rd_ff * b_rd_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      last_k_in    = last_k_ff;
      acc_in       = prod_v_ff ? acc_ff + prod_ff : acc_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.req_type == smm_pkg::REQ_READ)) begin
               row_in    = req_data.row_index;
               col_in    = req_data.col_index;
               k_in      = '0;
               last_k_in = K_W'(act_size - SZ_W'(1));
               acc_in    = '0;
               if (in_range) begin
                  state_in = ST_RUN;
               end else begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.out_row       = req_data.row_index;
                  rsp_data_in.out_col       = req_data.col_index;
                  rsp_data_in.product_value = '0;
                  rsp_data_in.out_of_range  = 1'b1;
               end
            end
         end
         ST_RUN: begin
            k_in = k_ff + K_W'(1);
            if (k_ff == last_k_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !prod_v_ff) begin
               state_in                  = ST_IDLE;
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_row       = row_ff;
               rsp_data_in.out_col       = col_ff;
               rsp_data_in.product_value = acc_ff;
               rsp_data_in.out_of_range  = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         matrix_size_ff <= smm_pkg::MATRIX_SIZE_RESET;
         rd_v_ff        <= 1'b0;
         prod_v_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         matrix_size_ff <= matrix_size_in;
         rd_v_ff        <= (state_ff == ST_RUN);
         prod_v_ff      <= rd_v_ff;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      k_ff        <= k_in;
      last_k_ff   <= last_k_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/smm_checker.sv @@
// smm_sva: port-level assertions for square_matrix_multiply_top, bound to the top level
// depends on smm_pkg

module smm_sva (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input smm_pkg::req_beat_type req_data,
   input logic                  rsp_valid,
   input smm_pkg::rsp_beat_type rsp_data
);

   // flagged result carries a zero product
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |-> rsp_data.product_value == 32'd0)
      else $error("flagged result with nonzero product");

   // a load beat never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.req_type == smm_pkg::REQ_LOAD) |=> !rsp_valid)
      else $error("result after load beat");

   // a read beat either answers at once or starts the mac walk
   a_read_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.req_type == smm_pkg::REQ_READ) |=> busy || rsp_valid)
      else $error("read beat dropped");

   // end of a walk delivers its result
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && !rsp_data.out_of_range)
      else $error("walk ended without result");

   // an in-range result only follows a walk
   a_result_after_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_of_range |-> $past(busy))
      else $error("computed result without walk");

endmodule

bind square_matrix_multiply_top smm_sva u_smm_sva (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
